/* sv/stack_bytecode_expression_evaluator_unit_defines.svh */
// assertion macros used by the port checker
`ifndef STACK_BYTECODE_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off in reset
`define SBEE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBEE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sbee_pkg.sv */
// ----------------------------------------------------------------------------
// sbee_pkg
// types, sizes and opcode codes of the stack bytecode evaluator
// ----------------------------------------------------------------------------
package sbee_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int VAR_SLOTS   = 256;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W      = $clog2(STACK_DEPTH);
	localparam int VIDX_W      = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
	localparam int VCNT_W      = 9;

	localparam logic [7:0] OP_PUSH_LIT  = 8'd0;
	localparam logic [7:0] OP_FETCH_VAR = 8'd1;
	localparam logic [7:0] OP_ADD       = 8'd2;
	localparam logic [7:0] OP_SUB       = 8'd3;
	localparam logic [7:0] OP_MUL       = 8'd4;
	localparam logic [7:0] OP_NEG       = 8'd5;
	localparam logic [7:0] OP_EQ        = 8'd6;
	localparam logic [7:0] OP_NE        = 8'd7;
	localparam logic [7:0] OP_LT        = 8'd8;
	localparam logic [7:0] OP_LE        = 8'd9;
	localparam logic [7:0] OP_GT        = 8'd10;
	localparam logic [7:0] OP_GE        = 8'd11;
	localparam logic [7:0] OP_AND       = 8'd12;
	localparam logic [7:0] OP_OR        = 8'd13;
	localparam logic [7:0] OP_NOT       = 8'd14;

	localparam logic [2:0] SET_STORE = 3'd1;
	localparam logic [2:0] SET_ADD   = 3'd2;
	localparam logic [2:0] SET_SUB   = 3'd3;
	localparam logic [2:0] SET_MUL   = 3'd4;

	typedef enum logic [3:0] {
		ALU_PASS, ALU_ADD, ALU_SUB, ALU_MUL, ALU_EQ, ALU_NE,
		ALU_LT, ALU_LE, ALU_GT, ALU_GE, ALU_AND, ALU_OR
	} alu_op_t;

	function automatic alu_op_t alu_of_opcode(input logic [7:0] op);
		alu_op_t r;
		case (op)
			OP_ADD:  r = ALU_ADD;
			OP_SUB:  r = ALU_SUB;
			OP_MUL:  r = ALU_MUL;
			OP_NEG:  r = ALU_SUB;
			OP_EQ:   r = ALU_EQ;
			OP_NE:   r = ALU_NE;
			OP_LT:   r = ALU_LT;
			OP_LE:   r = ALU_LE;
			OP_GT:   r = ALU_GT;
			OP_GE:   r = ALU_GE;
			OP_AND:  r = ALU_AND;
			OP_OR:   r = ALU_OR;
			OP_NOT:  r = ALU_EQ;
			default: r = ALU_PASS;
		endcase
		return r;
	endfunction

	function automatic alu_op_t alu_of_setter(input logic [2:0] sop);
		alu_op_t r;
		case (sop)
			SET_ADD: r = ALU_ADD;
			SET_SUB: r = ALU_SUB;
			SET_MUL: r = ALU_MUL;
			default: r = ALU_PASS;
		endcase
		return r;
	endfunction

endpackage

/* sv/sbee_alu.sv */
// ----------------------------------------------------------------------------
// sbee_alu
// shared arithmetic and compare unit, one operation per use
// ----------------------------------------------------------------------------
module sbee_alu (
	input  sbee_pkg::alu_op_t op,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic [31:0]       y
);
	import sbee_pkg::*;

	logic lt_ab;
	logic lt_ba;

	assign lt_ab = $signed(a) < $signed(b);
	assign lt_ba = $signed(b) < $signed(a);

	always_comb begin
		case (op)
			ALU_PASS: y = b;
			ALU_ADD:  y = a + b;
			ALU_SUB:  y = a - b;
			ALU_MUL:  y = a * b;
			ALU_EQ:   y = {31'd0, a == b};
			ALU_NE:   y = {31'd0, a != b};
			ALU_LT:   y = {31'd0, lt_ab};
			ALU_LE:   y = {31'd0, !lt_ba};
			ALU_GT:   y = {31'd0, lt_ba};
			ALU_GE:   y = {31'd0, !lt_ab};
			ALU_AND:  y = {31'd0, (a != 32'd0) && (b != 32'd0)};
			ALU_OR:   y = {31'd0, (a != 32'd0) || (b != 32'd0)};
			default:  y = b;
		endcase
	end
endmodule

/* sv/stack_bytecode_expression_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// stack_bytecode_expression_evaluator_unit
// byte-serial stack machine with one shared alu and a small sequencer
// ----------------------------------------------------------------------------
// steps: a load item is written in idle; operand bytes are decoded and pushed;
// ops pop b (and a), execute, push; a last byte pops, runs the setter, outputs
// throughput: one item at a time, input ready only while the sequencer is idle
// reset: arst_n clears sequencer, stack count, operand state and var_count;
// stack and variable memories are not cleared
module stack_bytecode_expression_evaluator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// code_byte[7:0] setter_op[10:8] setter_var[26:11] load_index[34:27]
	// load_value[66:35], zero pad above
	input  logic [71:0] s_tdata,
	// action
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// value[31:0]
	output logic [31:0] m_tdata,
	// failed[0] applied[1]
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import sbee_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_DEC  = 14'b00000000000010,
		S_VRD  = 14'b00000000000100,
		S_POPB = 14'b00000000001000,
		S_POPA = 14'b00000000010000,
		S_CAPA = 14'b00000000100000,
		S_EXE  = 14'b00000001000000,
		S_PUSH = 14'b00000010000000,
		S_END  = 14'b00000100000000,
		S_FPOP = 14'b00001000000000,
		S_SRD  = 14'b00010000000000,
		S_SLD  = 14'b00100000000000,
		S_SWR  = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] var_mem [VAR_SLOTS];

	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        phase_q;
	logic              isvar_q;
	logic [31:0]       accum_q;
	logic              fail_q;
	logic [VCNT_W-1:0] var_count_q;

	logic [7:0]  byte_q;
	logic        last_q;
	logic [2:0]  sop_q;
	logic [15:0] svar_q;

	logic [31:0] rd_q;
	logic [31:0] vrd_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] push_q;
	alu_op_t     op_q;
	logic        unary_q;
	logic        apply_q;

	logic [31:0] value_q;
	logic        failed_q;
	logic        applied_q;

	logic              accept;
	logic [VCNT_W-1:0] eff_cnt;
	logic [2:0]        pos;
	logic [31:0]       accum_new;
	logic [15:0]       var_idx;
	logic [CNT_W-1:0]  top_idx;
	logic [CNT_W-1:0]  next_idx;
	logic [31:0]       alu_y;
	logic              end_failed;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == S_OUT);
	assign m_tdata   = value_q;
	assign m_tuser   = {applied_q, failed_q};

	assign eff_cnt = (var_count_q < VCNT_W'(VAR_SLOTS)) ? var_count_q : VCNT_W'(VAR_SLOTS);
	assign pos       = (isvar_q ? 3'd2 : 3'd4) - phase_q;
	assign accum_new = accum_q | ({24'd0, byte_q} << {pos[1:0], 3'b000});
	assign var_idx   = accum_new[15:0];
	assign top_idx   = cnt_q - CNT_W'(1);
	assign next_idx  = cnt_q - CNT_W'(2);
	assign end_failed = fail_q || (phase_q != 3'd0);

	sbee_alu u_alu (
		.op (op_q),
		.a  (a_q),
		.b  (b_q),
		.y  (alu_y)
	);

	// memories, no reset
	always_ff @(posedge clk) begin
		if (accept && s_tuser) begin
			var_mem[s_tdata[27 +: VIDX_W]] <= s_tdata[66:35];
		end else if (state_q == S_SWR && apply_q) begin
			var_mem[svar_q[VIDX_W-1:0]] <= alu_y;
		end
		if (state_q == S_DEC) begin
			vrd_q <= var_mem[var_idx[VIDX_W-1:0]];
		end else if (state_q == S_SRD) begin
			vrd_q <= var_mem[svar_q[VIDX_W-1:0]];
		end
		if (state_q == S_PUSH && cnt_q < CNT_W'(STACK_DEPTH)) begin
			stack_mem[cnt_q[SIDX_W-1:0]] <= push_q;
		end
		if (state_q == S_POPA) begin
			rd_q <= stack_mem[next_idx[SIDX_W-1:0]];
		end else begin
			rd_q <= stack_mem[top_idx[SIDX_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_tdata[7:0];
			last_q <= s_tlast;
			sop_q  <= s_tdata[10:8];
			svar_q <= s_tdata[26:11];
		end
		case (state_q)
			S_DEC: begin
				op_q    <= alu_of_opcode(byte_q);
				unary_q <= (byte_q == OP_NEG) || (byte_q == OP_NOT);
				push_q  <= (isvar_q) ? 32'd0 : accum_new;
			end
			S_VRD:  push_q <= vrd_q;
			S_POPA: begin
				b_q <= (cnt_q != '0) ? rd_q : 32'd0;
				if (unary_q) begin
					a_q <= 32'd0;
				end
			end
			S_CAPA: a_q <= (cnt_q != '0) ? rd_q : 32'd0;
			S_EXE:  push_q <= alu_y;
			S_END: begin
				b_q <= 32'd0;
				failed_q <= end_failed;
				op_q <= alu_of_setter(sop_q);
				apply_q <= (sop_q >= SET_STORE) && (sop_q <= SET_MUL) &&
					(svar_q < {7'd0, eff_cnt});
			end
			S_FPOP: b_q <= (cnt_q != '0) ? rd_q : 32'd0;
			S_SLD:  a_q <= vrd_q;
			S_SWR: begin
				value_q   <= b_q;
				applied_q <= apply_q;
			end
			default: ;
		endcase
	end

	// sequencer and expression state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			phase_q     <= 3'd0;
			isvar_q     <= 1'b0;
			accum_q     <= 32'd0;
			fail_q      <= 1'b0;
			var_count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				var_count_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !s_tuser) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (fail_q) begin
						state_q <= S_END;
					end else if (phase_q != 3'd0) begin
						phase_q <= phase_q - 3'd1;
						if (phase_q == 3'd1) begin
							accum_q <= 32'd0;
							isvar_q <= 1'b0;
							if (isvar_q && ({7'd0, eff_cnt} > var_idx)) begin
								state_q <= S_VRD;
							end else begin
								state_q <= S_PUSH;
							end
						end else begin
							accum_q <= accum_new;
							state_q <= S_END;
						end
					end else if (byte_q == OP_PUSH_LIT || byte_q == OP_FETCH_VAR) begin
						isvar_q <= (byte_q == OP_FETCH_VAR);
						phase_q <= (byte_q == OP_FETCH_VAR) ? 3'd2 : 3'd4;
						accum_q <= 32'd0;
						state_q <= S_END;
					end else if (byte_q > OP_NOT) begin
						fail_q  <= 1'b1;
						state_q <= S_END;
					end else begin
						state_q <= S_POPB;
					end
				end
				S_VRD:  state_q <= S_PUSH;
				S_POPB: state_q <= S_POPA;
				S_POPA: begin
					// b is captured here, a read issued in the same cycle
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
					state_q <= unary_q ? S_EXE : S_CAPA;
				end
				S_CAPA: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
					state_q <= S_EXE;
				end
				S_EXE:  state_q <= S_PUSH;
				S_PUSH: begin
					if (cnt_q < CNT_W'(STACK_DEPTH)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= S_END;
				end
				S_END: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (end_failed) begin
						state_q <= S_SRD;
					end else begin
						state_q <= S_FPOP;
					end
				end
				S_FPOP: state_q <= S_SRD;
				S_SRD:  state_q <= S_SLD;
				S_SLD:  state_q <= S_SWR;
				S_SWR: begin
					cnt_q   <= '0;
					phase_q <= 3'd0;
					isvar_q <= 1'b0;
					accum_q <= 32'd0;
					fail_q  <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/sbee_checker.sv */
// ----------------------------------------------------------------------------
// sbee_checker
// port-level checks on the evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "stack_bytecode_expression_evaluator_unit_defines.svh"

module sbee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	// no new item while a result waits
	`SBEE_ASSERT_IMP(a_excl, m_tvalid, !s_tready, "input ready while result pending")
	// a failed result carries zero
	`SBEE_ASSERT_IMP(a_failzero, m_tvalid && m_tuser[0], m_tdata == 32'd0, "failed nonzero")
	// an expression byte occupies the unit
	`SBEE_ASSERT_NXT(a_busy, s_tvalid && s_tready && !s_tuser, !s_tready, "not busy after byte")
	// a load item keeps the input open
	`SBEE_ASSERT_NXT(a_load, s_tvalid && s_tready && s_tuser, s_tready, "load stalled")
	`SBEE_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

bind stack_bytecode_expression_evaluator_unit sbee_checker u_sbee_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/stack_bytecode_expression_evaluator_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_expression_evaluator_unit_checker
// watches the input, output and register channels, predicts each result
// from its own copy of the stack, operand state and variable store
// ----------------------------------------------------------------------------
module stack_bytecode_expression_evaluator_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// code_byte[7:0] setter_op[10:8] setter_var[26:11] load_index[34:27]
	// load_value[66:35], zero pad above
	input  logic [71:0] s_tdata,
	// action
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// value[31:0]
	input  logic [31:0] m_tdata,
	// failed[0] applied[1]
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	import sbee_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        failed;
		logic        applied;
	} eval_result_t;

	eval_result_t result_q[$];

	logic [31:0] stk[STACK_DEPTH];
	int          stk_cnt;
	int          opnd_left;
	logic        opnd_var;
	logic [31:0] opnd_acc;
	logic        fail_flag;
	logic [31:0] vars[VAR_SLOTS];
	logic [8:0]  var_cnt;

	function automatic int vars_live();
		return (var_cnt < VAR_SLOTS) ? int'(var_cnt) : VAR_SLOTS;
	endfunction

	function automatic void stk_push(logic [31:0] v);
		if (stk_cnt < STACK_DEPTH) begin
			stk[stk_cnt] = v;
			stk_cnt++;
		end
	endfunction

	function automatic logic [31:0] stk_pop();
		if (stk_cnt == 0)
			return 32'd0;
		stk_cnt--;
		return stk[stk_cnt];
	endfunction

	function automatic void clear_expr();
		stk_cnt   = 0;
		opnd_left = 0;
		opnd_var  = 1'b0;
		opnd_acc  = '0;
		fail_flag = 1'b0;
	endfunction

	function automatic void eval_byte(logic [7:0] b);
		logic [31:0] x;
		logic [31:0] y;
		int          pos;
		if (opnd_left != 0) begin
			pos = (opnd_var ? 2 : 4) - opnd_left;
			opnd_acc = opnd_acc | (32'(b) << (8 * (pos & 3)));
			opnd_left--;
			if (opnd_left == 0) begin
				if (opnd_var)
					stk_push((int'(opnd_acc[15:0]) < vars_live()) ? vars[opnd_acc[7:0]] : 32'd0);
				else
					stk_push(opnd_acc);
				opnd_acc = '0;
				opnd_var = 1'b0;
			end
			return;
		end
		if (b == OP_PUSH_LIT || b == OP_FETCH_VAR) begin
			opnd_var  = (b == OP_FETCH_VAR);
			opnd_left = opnd_var ? 2 : 4;
			opnd_acc  = '0;
			return;
		end
		if (b == OP_NEG) begin
			stk_push(32'd0 - stk_pop());
			return;
		end
		if (b == OP_NOT) begin
			stk_push({31'd0, stk_pop() == 32'd0});
			return;
		end
		if (b > OP_NOT) begin
			fail_flag = 1'b1;
			return;
		end
		y = stk_pop();
		x = stk_pop();
		case (b)
			OP_ADD:  stk_push(x + y);
			OP_SUB:  stk_push(x - y);
			OP_MUL:  stk_push(x * y);
			OP_EQ:   stk_push({31'd0, x == y});
			OP_NE:   stk_push({31'd0, x != y});
			OP_LT:   stk_push({31'd0, $signed(x) < $signed(y)});
			OP_LE:   stk_push({31'd0, $signed(x) <= $signed(y)});
			OP_GT:   stk_push({31'd0, $signed(x) > $signed(y)});
			OP_GE:   stk_push({31'd0, $signed(x) >= $signed(y)});
			OP_AND:  stk_push({31'd0, x != 0 && y != 0});
			default: stk_push({31'd0, x != 0 || y != 0});
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// one input item accepted: update state, queue a result on a last byte
	task automatic predict_item();
		logic [7:0]   code;
		logic [2:0]   sop;
		logic [15:0]  svar;
		eval_result_t r;
		code = s_tdata[7:0];
		sop  = s_tdata[10:8];
		svar = s_tdata[26:11];
		if (s_tuser) begin
			vars[s_tdata[34:27]] = s_tdata[66:35];
			return;
		end
		if (!fail_flag)
			eval_byte(code);
		if (!s_tlast)
			return;
		r.failed  = fail_flag || opnd_left != 0;
		r.value   = r.failed ? 32'd0 : stk_pop();
		r.applied = 1'b0;
		if (sop >= SET_STORE && sop <= SET_MUL && int'(svar) < vars_live()) begin
			case (sop)
				SET_STORE: vars[svar[7:0]] = r.value;
				SET_ADD:   vars[svar[7:0]] = vars[svar[7:0]] + r.value;
				SET_SUB:   vars[svar[7:0]] = vars[svar[7:0]] - r.value;
				default:   vars[svar[7:0]] = vars[svar[7:0]] * r.value;
			endcase
			r.applied = 1'b1;
		end
		clear_expr();
		result_q.insert(result_q.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		eval_result_t want;
		if (!arst_n) begin
			clear_expr();
			var_cnt = '0;
			result_q.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report("unexpected result item", m_tdata, 32'd0);
				end else begin
					want = result_q.pop_front();
					if (m_tdata !== want.value)
						report("value", m_tdata, want.value);
					if (m_tuser[0] !== want.failed)
						report("failed", 32'(m_tuser[0]), 32'(want.failed));
					if (m_tuser[1] !== want.applied)
						report("applied", 32'(m_tuser[1]), 32'(want.applied));
				end
			end
			if (cfg_valid && cfg_ready)
				var_cnt = cfg_data;
			if (s_tvalid && s_tready)
				predict_item();
		end
		pending = result_q.size();
	end

endmodule

/* verif/stack_bytecode_expression_evaluator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_expression_evaluator_unit_tb
// fills the variable store, then runs directed and random bytecode
// expressions under several var_count settings with random stalls on both
// streams; the checker predicts and compares every result item
// ----------------------------------------------------------------------------
module stack_bytecode_expression_evaluator_unit_tb;
	import sbee_pkg::*;

	typedef struct {
		logic        action;
		logic [7:0]  code;
		logic        last;
		logic [2:0]  sop;
		logic [15:0] svar;
		logic [7:0]  lidx;
		logic [31:0] lval;
	} bc_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;
	int          fail_count;
	int          pending;

	int       items_sent;
	int       results_seen;
	logic     burst_mode;
	bc_item_t expr_q[$];

	stack_bytecode_expression_evaluator_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	stack_bytecode_expression_evaluator_unit_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("FAIL");
		$finish;
	end

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 17);
	endfunction

	// receiver: random waits per item, one long hold-off to back up the block
	initial begin
		int wait_cycles;
		results_seen = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_cycles = (results_seen == 8) ? 600 : draw_gap();
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
		end
	end

	task automatic send_item(input bc_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, it.lval, it.lidx, it.svar, it.sop, it.code};
		s_tuser  <= it.action;
		s_tlast  <= it.last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if ($urandom_range(0, 40) == 0)
			burst_mode = ~burst_mode;
	endtask

	function automatic bc_item_t rand_item();
		bc_item_t it;
		it.action = 1'b0;
		it.code   = 8'($urandom);
		it.last   = 1'b0;
		it.sop    = 3'($urandom);
		it.svar   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		it.lidx   = 8'($urandom);
		it.lval   = $urandom;
		return it;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		bc_item_t it;
		it = rand_item();
		it.code = b;
		expr_q.insert(expr_q.size(), it);
	endfunction

	function automatic logic [31:0] rand_lit();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 3));
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_lit(input logic [31:0] v);
		add_byte(OP_PUSH_LIT);
		for (int k = 0; k < 4; k++)
			add_byte(v[8*k +: 8]);
	endfunction

	function automatic void add_var(input logic [15:0] idx);
		add_byte(OP_FETCH_VAR);
		add_byte(idx[7:0]);
		add_byte(idx[15:8]);
	endfunction

	// sends the queued bytes, marking the final one as last
	task automatic send_expr();
		expr_q[expr_q.size() - 1].last = 1'b1;
		while (expr_q.size() > 0)
			send_item(expr_q.pop_front());
	endtask

	function automatic void build_expr();
		int depth;
		int ops;
		int kind;
		logic [7:0] op;
		depth = 0;
		ops = $urandom_range(0, 6);
		kind = $urandom_range(0, 9);
		// kinds 0..6 well formed, the rest carry a fault
		while (ops > 0 || depth != 1) begin
			if (depth < 2 && !(depth == 1 && ops > 0 && $urandom_range(0, 2) == 0)) begin
				if ($urandom_range(0, 1))
					add_lit(rand_lit());
				else
					add_var(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)));
				depth++;
			end else begin
				op = 8'($urandom_range(OP_ADD, OP_NOT));
				if (op == OP_NEG || op == OP_NOT) begin
					add_byte(op);
				end else if (depth >= 2) begin
					add_byte(op);
					depth--;
				end else begin
					add_lit(rand_lit());
					depth++;
					continue;
				end
				if (ops > 0)
					ops--;
			end
		end
		case (kind)
			7: begin
				// unknown opcode somewhere in the stream
				expr_q.insert($urandom_range(0, expr_q.size() - 1), rand_item());
				expr_q[0].code = 8'($urandom_range(OP_NOT + 1, 255));
				expr_q.insert($urandom_range(0, expr_q.size()), expr_q[0]);
				void'(expr_q.pop_front());
			end
			8: begin
				// operand at the end with up to two bytes, truncated unless a complete var fetch
				if ($urandom_range(0, 1))
					add_byte(OP_PUSH_LIT);
				else
					add_byte(OP_FETCH_VAR);
				for (int k = $urandom_range(0, 2); k > 0; k--)
					add_byte(8'($urandom));
			end
			9: begin
				// push 30 to 36 more literals, often past full, then 30 to 40 random operators
				for (int k = $urandom_range(30, 36); k > 0; k--)
					add_lit($urandom);
				for (int k = $urandom_range(30, 40); k > 0; k--)
					add_byte(8'($urandom_range(OP_ADD, OP_NOT)));
			end
			default: ;
		endcase
	endfunction

	task automatic write_var_count(input logic [8:0] v);
		s_tvalid <= 1'b0;
		// let the last accepted item reach the checker before waiting on it
		repeat (20) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		bc_item_t it;
		logic [8:0] phase_cnt[7];
		int phase;
		phase_cnt = '{9'd256, 9'd0, 9'd1, 9'd255, 9'd300, 9'd17, 9'd511};
		items_sent = 0;
		burst_mode = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every variable slot before anything reads one
		for (int i = 0; i < VAR_SLOTS; i++) begin
			it = rand_item();
			it.action = 1'b1;
			it.lidx   = 8'(i);
			it.last   = ($urandom_range(0, 3) == 0);
			it.lval   = (i == 0) ? 32'h8000_0000 : (i == 255) ? 32'h7fff_ffff : $urandom;
			send_item(it);
		end
		write_var_count(9'd256);

		// directed: empty pop, unknown opcode, truncation, extremes, setters
		add_byte(OP_ADD);
		expr_q[0].sop = SET_STORE;
		expr_q[0].svar = 16'd0;
		send_expr();
		add_byte(8'hff);
		send_expr();
		add_byte(OP_PUSH_LIT);
		add_byte(8'h12);
		expr_q[1].sop = SET_ADD;
		expr_q[1].svar = 16'd5;
		send_expr();
		add_var(16'd255);
		add_lit(32'h8000_0000);
		add_byte(OP_MUL);
		expr_q[expr_q.size() - 1].sop = SET_MUL;
		expr_q[expr_q.size() - 1].svar = 16'd255;
		send_expr();
		add_lit(32'h7fff_ffff);
		add_byte(OP_NEG);
		add_byte(OP_NOT);
		expr_q[expr_q.size() - 1].sop = SET_SUB;
		expr_q[expr_q.size() - 1].svar = 16'hffff;
		send_expr();

		for (phase = 0; phase < 7; phase++) begin
			write_var_count(phase_cnt[phase]);
			while (items_sent < 256 + 25 + (phase + 1) * 110) begin
				if ($urandom_range(0, 9) == 0) begin
					it = rand_item();
					it.action = 1'b1;
					it.last = 1'b1 & 1'($urandom);
					send_item(it);
				end else begin
					build_expr();
					send_expr();
				end
			end
		end

		s_tvalid <= 1'b0;
		repeat (40) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
